[hw/rtl/tsw3cm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-colour marker package
// Shared widths, register indexes, colour codes and the command bundle
// that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package tsw3cm_pkg;

    // Fraction bits of the rate format (Q8.24 at the default).
    localparam int RATE_FRAC_BITS = 24;

    localparam int RATE_W   = 32;
    localparam int WIN_W    = 24;
    localparam int TIME_W   = 32;
    localparam int BYTES_W  = 16;
    localparam int RAND_W   = 16;
    localparam int OVH_W    = 8;
    localparam int COLOUR_W = 2;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Numerator of the rate update: rate * window plus the shifted byte count.
    localparam int NUM_W   = RATE_W + WIN_W + 1;
    // Divisor: wrapped tick gap plus window.
    localparam int DEN_W   = TIME_W + 1;
    // Bytes plus overhead.
    localparam int SUM_W   = BYTES_W + 1;
    // Scale factor 65536 - random, one bit wider than the random sample.
    localparam int SCALE_W = RAND_W + 1;
    localparam int SPROD_W = RATE_W + SCALE_W;

    // Quotient bits produced by the restoring divider, one per step.
    localparam int DIV_STEPS = RATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(1000);
    localparam logic [RATE_W-1:0]  RATE_MAX     = '1;
    localparam logic [SCALE_W-1:0] SCALE_ONE    = SCALE_W'(1) << RAND_W;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_TICKS   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_COMMITTED_RATE = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_RATE      = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_OVERHEAD_BYTES = CFG_INDEX_W'(3);

    // Packet colours.
    localparam logic [COLOUR_W-1:0] COLOUR_GREEN  = COLOUR_W'(0);
    localparam logic [COLOUR_W-1:0] COLOUR_YELLOW = COLOUR_W'(1);
    localparam logic [COLOUR_W-1:0] COLOUR_RED    = COLOUR_W'(2);

    typedef struct packed {
        logic load;      // capture the incoming item
        logic mul;       // rate * window, tick gap, divisor
        logic sum;       // form the numerator
        logic prep;      // saturation check and divider setup
        logic div_step;  // one quotient bit
        logic scale;     // random scaling of the new rate
        logic commit;    // write result and update meter state
    } t_cmd;

endpackage

[hw/rtl/tsw3cm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-colour marker controller
// Sequences one item at a time through the datapath and owns the
// handshake flags of both channels.
// ----------------------------------------------------------------------------
module tsw3cm_ctrl
    import tsw3cm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_SCALE,
        ST_OUT
    } t_state;

    t_state               r_state;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic                 r_out_valid;
    logic                 out_free;

    // The result register can take a new item when empty or being emptied.
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:  o_cmd.load     = i_in_valid;
            ST_MUL:   o_cmd.mul      = 1'b1;
            ST_SUM:   o_cmd.sum      = 1'b1;
            ST_PREP:  o_cmd.prep     = 1'b1;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_SCALE: o_cmd.scale    = 1'b1;
            ST_OUT:   o_cmd.commit   = out_free;
            default:  o_cmd          = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL:  r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_PREP;
                ST_PREP: begin
                    r_div_cnt <= '0;
                    r_state   <= ST_DIV;
                end
                ST_DIV: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= ST_SCALE;
                    end
                end
                ST_SCALE: r_state <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/tsw3cm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-colour marker datapath
// Configuration registers, meter state, one multiplier per step, a
// bit-serial restoring divider and the result register.
// ----------------------------------------------------------------------------
module tsw3cm_dp
    import tsw3cm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [TIME_W-1:0]      i_arrival_time,
    input  logic [BYTES_W-1:0]     i_packet_bytes,
    input  logic [RAND_W-1:0]      i_random_value,
    output logic [COLOUR_W-1:0]    o_colour,
    output logic [RATE_W-1:0]      o_average_rate
);

    // Configuration and meter state.
    logic [WIN_W-1:0]    r_window;
    logic [RATE_W-1:0]   r_committed;
    logic [RATE_W-1:0]   r_peak;
    logic [OVH_W-1:0]    r_overhead;
    logic [RATE_W-1:0]   r_rate;
    logic [TIME_W-1:0]   r_last;

    // Working registers for the item in flight.
    logic [TIME_W-1:0]   r_now;
    logic [BYTES_W-1:0]  r_bytes;
    logic [RAND_W-1:0]   r_rnd;
    logic [NUM_W-1:0]    r_prod;
    logic [NUM_W-1:0]    r_added;
    logic [DEN_W-1:0]    r_den;
    logic [NUM_W-1:0]    r_num;
    logic                r_sat;
    logic [DEN_W-1:0]    r_rem;
    logic [RATE_W-1:0]   r_quo;
    logic [RATE_W-1:0]   r_new_rate;
    logic [SPROD_W-1:0]  r_sprod;
    logic [COLOUR_W-1:0] r_colour;
    logic [RATE_W-1:0]   r_out_rate;

    logic [DEN_W:0]        n_trial;
    logic                  n_qbit;
    logic [DEN_W-1:0]      n_rem;
    logic [RATE_W-1:0]     n_new_rate;
    logic [SCALE_W-1:0]    n_factor;
    logic [RATE_W:0]       n_scaled;
    logic [COLOUR_W-1:0]   n_colour;
    logic [SUM_W-1:0]      n_bytes_sum;
    logic [TIME_W-1:0]     n_gap;

    // One restoring step: shift in the next dividend bit and try the divisor.
    always_comb begin
        n_trial = {r_rem, r_quo[RATE_W-1]};
        if (n_trial >= {1'b0, r_den}) begin
            n_qbit = 1'b1;
            n_rem  = DEN_W'(n_trial - {1'b0, r_den});
        end else begin
            n_qbit = 1'b0;
            n_rem  = n_trial[DEN_W-1:0];
        end
    end

    // The tick gap wraps at the width of the time field.
    assign n_gap       = r_now - r_last;
    assign n_bytes_sum = SUM_W'(r_bytes) + SUM_W'(r_overhead);
    assign n_new_rate  = r_sat ? RATE_MAX : r_quo;
    assign n_factor    = SCALE_ONE - SCALE_W'(r_rnd);
    assign n_scaled    = r_sprod[SPROD_W-1:RAND_W];

    always_comb begin
        if (n_scaled > {1'b0, r_peak}) begin
            n_colour = COLOUR_RED;
        end else if (n_scaled > {1'b0, r_committed}) begin
            n_colour = COLOUR_YELLOW;
        end else begin
            n_colour = COLOUR_GREEN;
        end
    end

    // Configuration and meter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_committed <= '0;
            r_peak      <= '0;
            r_overhead  <= '0;
            r_rate      <= '0;
            r_last      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WINDOW_TICKS:   r_window    <= i_cfg_data[WIN_W-1:0];
                    CFG_COMMITTED_RATE: r_committed <= i_cfg_data[RATE_W-1:0];
                    CFG_PEAK_RATE:      r_peak      <= i_cfg_data[RATE_W-1:0];
                    CFG_OVERHEAD_BYTES: r_overhead  <= i_cfg_data[OVH_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_rate <= r_new_rate;
                r_last <= r_now;
            end
        end
    end

    // Arithmetic pipeline of the item in flight; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now   <= i_arrival_time;
            r_bytes <= i_packet_bytes;
            r_rnd   <= i_random_value;
        end
        if (i_cmd.mul) begin
            r_prod  <= NUM_W'(r_rate) * NUM_W'(r_window);
            r_den   <= DEN_W'(n_gap) + DEN_W'(r_window);
            r_added <= NUM_W'(n_bytes_sum) << RATE_FRAC_BITS;
        end
        if (i_cmd.sum) begin
            r_num <= r_prod + r_added;
        end
        if (i_cmd.prep) begin
            // The quotient overflows 32 bits exactly when the upper part of
            // the numerator reaches the divisor; a zero divisor lands here too.
            r_sat <= (DEN_W'(r_num[NUM_W-1:RATE_W]) >= r_den);
            r_rem <= DEN_W'(r_num[NUM_W-1:RATE_W]);
            r_quo <= r_num[RATE_W-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[RATE_W-2:0], n_qbit};
        end
        if (i_cmd.scale) begin
            r_new_rate <= n_new_rate;
            r_sprod    <= SPROD_W'(n_new_rate) * SPROD_W'(n_factor);
        end
        if (i_cmd.commit) begin
            r_colour   <= n_colour;
            r_out_rate <= r_new_rate;
        end
    end

    assign o_colour       = r_colour;
    assign o_average_rate = r_out_rate;

endmodule

[hw/rtl/tsw_three_colour_marker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Time-sliding-window three-colour marker
// Single rate meter that updates a sliding-window average on every packet
// and marks the packet green, yellow or red against two rate thresholds.
// ----------------------------------------------------------------------------
// Usage:
// Packets enter on the input channel (i_in_valid / o_in_stall) with their
// arrival tick, length and a random sample. Each packet yields exactly one
// item on the output channel (o_out_valid / i_out_stall) carrying its colour
// and the updated average rate in Q8.24 bytes per tick.
// The block works on one item at a time and takes the next item in the
// cycle after the result is written. The restoring divider produces the 32
// quotient bits, one quotient bit per cycle, after the multiply, sum and
// setup steps and before the scale step and the result write.
// A new item may be accepted while the previous result still sits in the
// output register. If the receiver keeps stalling, the next finished item
// waits in the datapath and the input stays stalled until it can be written.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always ready and must
// only be issued while the block is idle. Indexes beyond three are ignored.
// Synchronous reset restores the window to 1000 ticks, clears both rate
// thresholds, the overhead, the rate estimate and the last arrival time.
// ----------------------------------------------------------------------------
module tsw_three_colour_marker
    import tsw3cm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [TIME_W-1:0]      i_arrival_time,
    input  logic [BYTES_W-1:0]     i_packet_bytes,
    input  logic [RAND_W-1:0]      i_random_value,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [COLOUR_W-1:0]    o_colour,
    output logic [RATE_W-1:0]      o_average_rate,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd cmd;

    // Registers are plain flops, so a write can always complete at once.
    assign o_cfg_ready = 1'b1;

    tsw3cm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    tsw3cm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_arrival_time (i_arrival_time),
        .i_packet_bytes (i_packet_bytes),
        .i_random_value (i_random_value),
        .o_colour       (o_colour),
        .o_average_rate (o_average_rate)
    );

    // An accepted item occupies the block, so the input stalls next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an item was accepted");

    // A result only appears after an item was being worked on.
    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in flight");

    // Only the three defined colours are ever presented.
    a_colour_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_colour == COLOUR_GREEN || o_colour == COLOUR_YELLOW ||
                         o_colour == COLOUR_RED))
        else $error("undefined colour code on the output");

    // A new result is written only when the previous one has been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> !$fell(o_in_stall))
        else $error("block went idle while a result was still stalled");

endmodule
